// File: rtl/row_gaussian_blur_renormalized_assert.svh
// assertion macros used by the checker file
`ifndef ROW_GAUSSIAN_BLUR_RENORMALIZED_ASSERT_SVH
`define ROW_GAUSSIAN_BLUR_RENORMALIZED_ASSERT_SVH

// checked at every clock edge outside reset
`define RGBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define RGBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/rgbr_pkg.sv
package rgbr_pkg;

  localparam int MaxRadius = 6;
  localparam int NumTaps   = 7;
  localparam int ChanW     = 8;
  localparam int NumChan   = 4;
  localparam int PixW      = ChanW * NumChan;
  localparam int WeightW   = 16;
  localparam int RadiusW   = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int QuotW     = 8;
  localparam int StepW     = $clog2(QuotW);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_WEIGHT_0 = 3'd1,
    CFG_WEIGHT_1 = 3'd2,
    CFG_WEIGHT_2 = 3'd3,
    CFG_WEIGHT_3 = 3'd4,
    CFG_WEIGHT_4 = 3'd5,
    CFG_WEIGHT_5 = 3'd6,
    CFG_WEIGHT_6 = 3'd7
  } cfg_idx_e;

  localparam logic [RadiusW-1:0] RadiusReset = 3'd2;
  localparam logic [NumTaps-1:0][WeightW-1:0] WeightReset = {
    16'd0, 16'd0, 16'd11, 16'd364, 16'd4435, 16'd19874, 16'd32768
  };

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
    logic             row_end;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
    logic             row_last;
  } pix_out_t;

endpackage

// File: rtl/row_gaussian_blur_renormalized.sv
// an emitting pixel is pushed into the job queue as it is accepted; the back end pops a job
// only when idle, runs the one-tap-a-cycle mac loop and the 8-step serial divider, then
// registers each result when the output is free; a row end gives up to radius+1 results
// input is taken one cycle per pixel while the two-deep job queue has room
// reset: window, valid marks and pending count cleared, radius 2, default q1.15 taps
module row_gaussian_blur_renormalized #(
  parameter int MaxRadius = rgbr_pkg::MaxRadius
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rgbr_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rgbr_pkg::pix_out_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rgbr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rgbr_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int Win   = 2 * MaxRadius + 1;
  localparam int IdxW  = $clog2(Win);
  localparam int PendW = $clog2(MaxRadius + 2);
  localparam int RadW  = $clog2(MaxRadius + 1);
  localparam int JobW  = Win * rgbr_pkg::PixW + Win + IdxW + PendW + 1;

  // configuration registers
  logic [rgbr_pkg::RadiusW-1:0]                      radius_q;
  logic [rgbr_pkg::NumTaps-1:0][rgbr_pkg::WeightW-1:0] weight_q;
  logic [RadW-1:0]                                   radius_eff;

  // front to queue
  logic                               in_accept, push;
  logic [Win-1:0][rgbr_pkg::PixW-1:0] f_win;
  logic [Win-1:0]                     f_vld;
  logic [IdxW-1:0]                    f_top;
  logic [PendW-1:0]                   f_cnt;
  logic                               f_last;

  // queue to back
  logic                               q_full, q_empty, pop;
  logic [JobW-1:0]                    q_rdata;
  logic [Win-1:0][rgbr_pkg::PixW-1:0] b_win;
  logic [Win-1:0]                     b_vld;
  logic [IdxW-1:0]                    b_top;
  logic [PendW-1:0]                   b_cnt;
  logic                               b_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rgbr_pkg::RadiusReset;
      weight_q <= rgbr_pkg::WeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbr_pkg::CFG_RADIUS:   radius_q    <= cfg_data_i[rgbr_pkg::RadiusW-1:0];
        rgbr_pkg::CFG_WEIGHT_0: weight_q[0] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_1: weight_q[1] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_2: weight_q[2] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_3: weight_q[3] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_4: weight_q[4] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_5: weight_q[5] <= cfg_data_i;
        rgbr_pkg::CFG_WEIGHT_6: weight_q[6] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // radius saturates at the window half width
  assign radius_eff = (int'(radius_q) > MaxRadius) ? RadW'(MaxRadius) : RadW'(radius_q);

  // front stalls only when the job queue is full
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  rgbr_front #(.MaxRadius(MaxRadius)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .pix_i      (in_data_i),
    .radius_i   (radius_eff),
    .push_o     (push),
    .job_win_o  (f_win),
    .job_vld_o  (f_vld),
    .job_top_o  (f_top),
    .job_cnt_o  (f_cnt),
    .job_last_o (f_last)
  );

  // each job carries its own window snapshot so the front can move on
  rgbr_fifo #(.Width(JobW), .Depth(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_win, f_vld, f_top, f_cnt, f_last}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_win, b_vld, b_top, b_cnt, b_last} = q_rdata;

  rgbr_back #(.MaxRadius(MaxRadius)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .pop_o       (pop),
    .job_win_i   (b_win),
    .job_vld_i   (b_vld),
    .job_top_i   (b_top),
    .job_cnt_i   (b_cnt),
    .job_last_i  (b_last),
    .radius_i    (radius_eff),
    .weight_i    (weight_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/rgbr_front.sv
module rgbr_front #(
  parameter int MaxRadius = rgbr_pkg::MaxRadius
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         accept_i,
  input  rgbr_pkg::pix_in_t                            pix_i,
  input  logic [$clog2(MaxRadius+1)-1:0]               radius_i,
  output logic                                         push_o,
  output logic [2*MaxRadius:0][rgbr_pkg::PixW-1:0]     job_win_o,
  output logic [2*MaxRadius:0]                         job_vld_o,
  output logic [$clog2(2*MaxRadius+1)-1:0]             job_top_o,
  output logic [$clog2(MaxRadius+2)-1:0]               job_cnt_o,
  output logic                                         job_last_o
);

  localparam int Win   = 2 * MaxRadius + 1;
  localparam int IdxW  = $clog2(Win);
  localparam int PendW = $clog2(MaxRadius + 2);

  logic [Win-1:0][rgbr_pkg::PixW-1:0] win_q;
  logic [Win-1:0]                     vld_q;
  logic [PendW-1:0]                   pend_q, pend_d;
  logic [PendW-1:0]                   pend_inc, r_ext, r_plus, n_end;
  logic [rgbr_pkg::PixW-1:0]          pix_word;

  assign pix_word = {pix_i.alpha_in, pix_i.blue_in, pix_i.green_in, pix_i.red_in};
  assign pend_inc = pend_q + PendW'(1);
  assign r_ext    = PendW'(radius_i);
  assign r_plus   = r_ext + PendW'(1);
  assign n_end    = (pend_inc > r_plus) ? r_plus : pend_inc;

  // job sees the window after the new pixel has shifted in
  assign job_win_o = {win_q[Win-2:0], pix_word};
  assign job_vld_o = {vld_q[Win-2:0], 1'b1};

  always_comb begin
    push_o     = 1'b0;
    job_top_o  = IdxW'(radius_i);
    job_cnt_o  = PendW'(1);
    job_last_o = 1'b0;
    pend_d     = pend_inc;
    if (pix_i.row_end) begin
      push_o     = accept_i;
      job_top_o  = IdxW'(n_end - PendW'(1));
      job_cnt_o  = n_end;
      job_last_o = 1'b1;
      pend_d     = '0;
    end else if (pend_inc > r_ext) begin
      push_o = accept_i;
      pend_d = r_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      vld_q  <= '0;
      pend_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      if (pix_i.row_end) begin
        win_q <= '0;
        vld_q <= '0;
      end else begin
        win_q <= job_win_o;
        vld_q <= job_vld_o;
      end
    end
  end

endmodule

// File: rtl/rgbr_fifo.sv
module rgbr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/rgbr_back.sv
module rgbr_back #(
  parameter int MaxRadius = rgbr_pkg::MaxRadius
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 job_valid_i,
  output logic                                                 pop_o,
  input  logic [2*MaxRadius:0][rgbr_pkg::PixW-1:0]             job_win_i,
  input  logic [2*MaxRadius:0]                                 job_vld_i,
  input  logic [$clog2(2*MaxRadius+1)-1:0]                     job_top_i,
  input  logic [$clog2(MaxRadius+2)-1:0]                       job_cnt_i,
  input  logic                                                 job_last_i,
  input  logic [$clog2(MaxRadius+1)-1:0]                       radius_i,
  input  logic [rgbr_pkg::NumTaps-1:0][rgbr_pkg::WeightW-1:0]  weight_i,
  input  logic                                                 out_stall_i,
  output logic                                                 out_valid_o,
  output rgbr_pkg::pix_out_t                                   out_data_o
);

  localparam int Win   = 2 * MaxRadius + 1;
  localparam int IdxW  = $clog2(Win);
  localparam int SIdxW = IdxW + 2;
  localparam int PendW = $clog2(MaxRadius + 2);
  localparam int SumW  = rgbr_pkg::WeightW + $clog2(Win);
  localparam int AccW  = rgbr_pkg::ChanW + SumW;
  localparam int NCh   = rgbr_pkg::NumChan;
  localparam int ChW   = rgbr_pkg::ChanW;
  localparam int QW    = rgbr_pkg::QuotW;
  localparam int StW   = rgbr_pkg::StepW;

  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_OUT} state_e;

  function automatic logic [rgbr_pkg::WeightW-1:0] tap_weight(
    input logic [SIdxW-1:0]                                tap_dist,
    input logic [rgbr_pkg::NumTaps-1:0][rgbr_pkg::WeightW-1:0] w
  );
    logic [rgbr_pkg::WeightW-1:0] res;
    res = '0;
    for (int j = 0; j < rgbr_pkg::NumTaps; j++) begin
      if (int'(tap_dist) == j) begin
        res = w[j];
      end
    end
    return res;
  endfunction

  state_e                             state_q;
  logic [Win-1:0][rgbr_pkg::PixW-1:0] win_q;
  logic [Win-1:0]                     vld_q;
  logic [IdxW-1:0]                    centre_q, t_q, t_last;
  logic [PendW-1:0]                   left_q;
  logic                               last_q;
  logic [NCh-1:0][AccW-1:0]           acc_q, acc_n;
  logic [SumW-1:0]                    wsum_q, wsum_n;
  logic [AccW-1:0]                    dv_q;
  logic [NCh-1:0][QW-1:0]             quo_q;
  logic [StW-1:0]                     step_q;
  logic                               out_valid_q;
  rgbr_pkg::pix_out_t                 out_data_q;

  logic signed [SIdxW-1:0]            idx_s, d_s;
  logic [SIdxW-1:0]                   dist_abs;
  logic                               take;
  logic [rgbr_pkg::PixW-1:0]          pix_sel;
  logic [rgbr_pkg::WeightW-1:0]       w_sel;
  logic [NCh-1:0]                     ge;
  logic                               out_free;

  assign t_last = IdxW'(radius_i) + IdxW'(radius_i);
  assign idx_s  = $signed(SIdxW'(centre_q)) + $signed(SIdxW'(t_q))
                - $signed(SIdxW'(radius_i));
  assign d_s    = $signed(SIdxW'(t_q)) - $signed(SIdxW'(radius_i));
  assign dist_abs = (d_s < 0) ? SIdxW'(-d_s) : SIdxW'(d_s);
  assign take   = (idx_s >= 0) && (idx_s < $signed(SIdxW'(Win)))
               && vld_q[idx_s[IdxW-1:0]];
  assign pix_sel = take ? win_q[idx_s[IdxW-1:0]] : '0;
  assign w_sel   = take ? tap_weight(dist_abs, weight_i) : '0;
  assign wsum_n  = wsum_q + SumW'(w_sel);

  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      acc_n[c] = acc_q[c] + AccW'(pix_sel[ChW*c +: ChW] * w_sel);
      ge[c]    = (acc_q[c] >= dv_q);
    end
  end

  assign pop_o       = (state_q == ST_IDLE) && job_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= '0;
      vld_q       <= '0;
      centre_q    <= '0;
      t_q         <= '0;
      left_q      <= '0;
      last_q      <= 1'b0;
      acc_q       <= '0;
      wsum_q      <= '0;
      dv_q        <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            win_q    <= job_win_i;
            vld_q    <= job_vld_i;
            centre_q <= job_top_i;
            left_q   <= job_cnt_i;
            last_q   <= job_last_i;
            t_q      <= '0;
            acc_q    <= '0;
            wsum_q   <= '0;
            state_q  <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc_q  <= acc_n;
          wsum_q <= wsum_n;
          t_q    <= t_q + IdxW'(1);
          if (t_q == t_last) begin
            dv_q    <= AccW'(wsum_n) << (QW - 1);
            step_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int c = 0; c < NCh; c++) begin
            if (ge[c]) begin
              acc_q[c] <= acc_q[c] - dv_q;
            end
            quo_q[c] <= {quo_q[c][QW-2:0], ge[c]};
          end
          dv_q   <= dv_q >> 1;
          step_q <= step_q + StW'(1);
          if (step_q == StW'(QW - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_data_q.red_out   <= (wsum_q == '0) ? '0 : quo_q[0];
            out_data_q.green_out <= (wsum_q == '0) ? '0 : quo_q[1];
            out_data_q.blue_out  <= (wsum_q == '0) ? '0 : quo_q[2];
            out_data_q.alpha_out <= (wsum_q == '0) ? '0 : quo_q[3];
            out_data_q.row_last  <= last_q && (left_q == PendW'(1));
            if (left_q == PendW'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              left_q   <= left_q - PendW'(1);
              centre_q <= centre_q - IdxW'(1);
              t_q      <= '0;
              acc_q    <= '0;
              wsum_q   <= '0;
              state_q  <= ST_ACC;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/rgbr_checker.sv
`include "row_gaussian_blur_renormalized_assert.svh"

module rgbr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rgbr_pkg::pix_out_t out_data_o
);

  logic [15:0] open_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // accepted pixels not yet matched by a result, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc && (open_q != 16'hffff)) begin
      open_q <= open_q + 16'd1;
    end else if (out_acc && !in_acc && (open_q != 16'hffff)) begin
      open_q <= open_q - 16'd1;
    end
  end

  `RGBR_ASSERT(out_valid_held, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `RGBR_ASSERT(out_data_held, out_valid_o && out_stall_i |=> $stable(out_data_o), "result changed")
  `RGBR_ASSERT(no_invented_out, out_acc |-> (open_q != 16'd0), "result without pixel")
  `RGBR_ASSERT_ALWAYS(quiet_in_reset, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind row_gaussian_blur_renormalized rgbr_checker u_rgbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: test/row_blur_scoreboard.sv
// watches both word channels and the config port, predicts blurred words, compares
module row_blur_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rgbr_pkg::pix_in_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rgbr_pkg::pix_out_t            out_data_i,
  input  logic                          cfg_we_i,
  input  logic [rgbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rgbr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            pending_words_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxRadius = rgbr_pkg::MaxRadius;
  localparam int NumTaps   = rgbr_pkg::NumTaps;
  localparam int PixW      = rgbr_pkg::PixW;
  localparam int RadiusW   = rgbr_pkg::RadiusW;
  localparam int WeightW   = rgbr_pkg::WeightW;
  localparam int Depth     = 2 * MaxRadius + 1;

  logic [PixW-1:0]              win_q [Depth];
  logic [Depth-1:0]             win_vld_q;
  int unsigned                  row_pend_q;
  logic [RadiusW-1:0]           radius_q;
  logic [NumTaps-1:0][WeightW-1:0] taps_q;
  rgbr_pkg::pix_out_t           blurred_q [$];

  assign pending_words_o = blurred_q.size();

  function automatic rgbr_pkg::pix_out_t blur_at(int ctr, int rad, logic last);
    rgbr_pkg::pix_out_t res;
    longint unsigned acc, wsum, w;
    logic [7:0]  chan [4];
    int          idx, tap_dist;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      wsum = 0;
      for (int d = -rad; d <= rad; d++) begin
        idx = ctr + d;
        tap_dist = d < 0 ? -d : d;
        if (idx < 0 || idx >= Depth || !win_vld_q[idx]) continue;
        w = tap_dist < NumTaps ? taps_q[tap_dist] : 0;
        acc += longint'(win_q[idx][8*ch +: 8]) * w;
        wsum += w;
      end
      chan[ch] = wsum != 0 ? 8'((acc / wsum) & 'hff) : 8'd0;
    end
    res.red_out   = chan[0];
    res.green_out = chan[1];
    res.blue_out  = chan[2];
    res.alpha_out = chan[3];
    res.row_last  = last;
    return res;
  endfunction

  task automatic take_pixel(rgbr_pkg::pix_in_t p);
    int rad;
    int n;
    rad = radius_q > MaxRadius ? MaxRadius : int'(radius_q);
    for (int i = Depth - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = {p.alpha_in, p.blue_in, p.green_in, p.red_in};
    win_vld_q = {win_vld_q[Depth-2:0], 1'b1};
    row_pend_q++;
    if (!p.row_end) begin
      if (row_pend_q > rad) begin
        blurred_q.push_back(blur_at(rad, rad, 1'b0));
        row_pend_q = rad;
      end
    end else begin
      // row end flushes what is still pending, oldest first
      if (row_pend_q > rad + 1) row_pend_q = rad + 1;
      n = int'(row_pend_q);
      for (int k = 0; k < n; k++) blurred_q.push_back(blur_at(n - 1 - k, rad, k == n - 1));
      for (int i = 0; i < Depth; i++) win_q[i] = '0;
      win_vld_q = '0;
      row_pend_q = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgbr_pkg::pix_out_t exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) win_q[i] = '0;
      win_vld_q = '0;
      row_pend_q = 0;
      radius_q = rgbr_pkg::RadiusReset;
      taps_q = rgbr_pkg::WeightReset;
      blurred_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rgbr_pkg::CFG_RADIUS) radius_q = cfg_data_i[RadiusW-1:0];
        else taps_q[cfg_idx_i - rgbr_pkg::CFG_WEIGHT_0] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected output word %h", out_data_i);
          fail_count_o++;
        end else begin
          exp_w = blurred_q.pop_front();
          if (out_data_i.red_out !== exp_w.red_out) begin
            $error("red_out exp %0d got %0d", exp_w.red_out, out_data_i.red_out);
            fail_count_o++;
          end
          if (out_data_i.green_out !== exp_w.green_out) begin
            $error("green_out exp %0d got %0d", exp_w.green_out, out_data_i.green_out);
            fail_count_o++;
          end
          if (out_data_i.blue_out !== exp_w.blue_out) begin
            $error("blue_out exp %0d got %0d", exp_w.blue_out, out_data_i.blue_out);
            fail_count_o++;
          end
          if (out_data_i.alpha_out !== exp_w.alpha_out) begin
            $error("alpha_out exp %0d got %0d", exp_w.alpha_out, out_data_i.alpha_out);
            fail_count_o++;
          end
          if (out_data_i.row_last !== exp_w.row_last) begin
            $error("row_last exp %0d got %0d", exp_w.row_last, out_data_i.row_last);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_pixel(in_data_i);
    end
  end
endmodule

// File: test/row_gaussian_blur_renormalized_tb.sv
module row_gaussian_blur_renormalized_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int CfgIdxW    = rgbr_pkg::CfgIdxW;
  localparam int CfgDataW   = rgbr_pkg::CfgDataW;
  localparam int NumTaps    = rgbr_pkg::NumTaps;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  rgbr_pkg::pix_in_t   in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rgbr_pkg::pix_out_t  out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  pending_words;
  int                  fail_count;

  // idling on both sides, cleared for the tail of the run
  bit                  idle_en;
  // request for one long receiver hold-off
  bit                  long_hold;
  int                  pix_sent;
  int                  cycle_cnt;

  row_gaussian_blur_renormalized u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  row_blur_scoreboard u_scoreboard (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .in_data_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .out_data_i      (out_data_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .pending_words_o (pending_words),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // one word into the block; valid stays high only across back-to-back words
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            logic last);
    bit taken;
    in_valid_i <= 1'b1;
    in_data_i  <= '{red_in: r, green_in: g, blue_in: b, alpha_in: a, row_end: last};
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pix_sent++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_pixel(logic last);
    logic [31:0] v;
    v = $urandom;
    send_pixel(v[7:0], v[15:8], v[23:16], v[31:24], last);
  endtask

  task automatic send_row(int len);
    for (int i = 0; i < len; i++) send_random_pixel(i == len - 1);
  endtask

  // sender pause: all words out, then room for work with no output yet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // one register write, enable dropped again before the next one
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd32768;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_taps_random();
    for (int k = 0; k < NumTaps; k++) begin
      write_reg(CfgIdxW'(rgbr_pkg::CFG_WEIGHT_0 + k), pick_weight());
    end
  endtask

  initial begin
    int len;
    int cut;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = rgbr_pkg::CFG_RADIUS;
    cfg_data_i  = '0;
    idle_en     = 1'b1;
    long_hold   = 1'b0;
    pix_sent    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset taps, extreme pixel values, row edges
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'haa, 8'h55, 8'hff, 8'h00, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h00, 8'hff, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h80, 8'h7f, 1'b1);
    // single pixel row
    send_pixel(8'hff, 8'h01, 8'h80, 8'hfe, 1'b1);
    drain();
    // radius zero passes pixels through
    write_reg(rgbr_pkg::CFG_RADIUS, 16'd0);
    send_row(3);
    drain();
    // radius above the maximum saturates, row end flushes up to seven words
    write_reg(rgbr_pkg::CFG_RADIUS, 16'd7);
    write_reg(rgbr_pkg::CFG_WEIGHT_6, 16'hffff);
    send_row(9);
    drain();
    // all taps zero gives zero output
    for (int k = 0; k < NumTaps; k++) write_reg(CfgIdxW'(rgbr_pkg::CFG_WEIGHT_0 + k), 16'd0);
    send_row(4);
    drain();
    // radius lowered mid-row drops older pending pixels
    write_taps_random();
    write_reg(rgbr_pkg::CFG_RADIUS, 16'd6);
    send_row(0);
    for (int i = 0; i < 5; i++) send_random_pixel(1'b0);
    drain();
    write_reg(rgbr_pkg::CFG_RADIUS, 16'd1);
    send_row(3);
    drain();

    // long receiver hold-off while a long row keeps coming
    write_reg(rgbr_pkg::CFG_RADIUS, 16'd6);
    long_hold = 1'b1;
    send_row(30);
    drain();

    while (pix_sent < 370) begin
      if (pix_sent > 320) idle_en = 1'b0;
      write_reg(rgbr_pkg::CFG_RADIUS, 16'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 0) write_taps_random();
      for (int r = $urandom_range(1, 3); r > 0; r--) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 20);
        if ($urandom_range(0, 4) == 0) begin
          // radius change part way through the row
          cut = $urandom_range(1, len);
          for (int i = 0; i < cut; i++) send_random_pixel(1'b0);
          drain();
          write_reg(rgbr_pkg::CFG_RADIUS, 16'($urandom_range(0, 7)));
          send_row(len - cut + 1);
        end else begin
          send_row(len);
        end
      end
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: row_gaussian_blur_renormalized.f
+incdir+rtl
rtl/rgbr_pkg.sv
rtl/rgbr_front.sv
rtl/rgbr_fifo.sv
rtl/rgbr_back.sv
rtl/row_gaussian_blur_renormalized.sv
rtl/rgbr_checker.sv
test/row_blur_scoreboard.sv
test/row_gaussian_blur_renormalized_tb.sv
